// ===== rtl/tt2anf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tt2anf_pkg
// shared types, codes and constants of the truth table to anf transform unit
// ----------------------------------------------------------------------------
package tt2anf_pkg;

    localparam int DEF_MAX_VARS = 10;
    localparam int NV_W         = 4;
    localparam int IDX_W        = 10;
    localparam int FUNC_W       = 2;
    localparam int XW           = 17;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RUN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic load_imm;
        logic load_read;
        logic load_done;
        logic run_start;
        logic run_issue;
        logic level_next;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              idx_err;
        logic              run_err;
        logic              nv_zero;
        logic              last_pair;
        logic              last_level;
        logic              out_valid;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== rtl/truth_table_to_anf_transform_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// truth_table_to_anf_transform_unit
// truth table to algebraic normal form converter (binary mobius transform)
// ----------------------------------------------------------------------------
// Requests on the slave stream write one truth-table bit (func write), run
// the in-place transform over the first 2^num_vars entries (func run) or read
// one coefficient (func read); every request returns exactly one result. A
// write, an out-of-range access, a refused run or an unused code is answered
// from the idle state, so these go back to back while results are taken. A
// read passes through the read state, because the coefficient memory has
// registered read data. In a run the memory updates one butterfly pair per
// cycle, and each level ends with a drain state that lets the last write
// land before the next level reads. Entries must be written before they
// are read or transformed.
// ----------------------------------------------------------------------------
module truth_table_to_anf_transform_unit
    import tt2anf_pkg::*;
#(
    parameter int MAX_VARS = DEF_MAX_VARS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [NV_W-1:0]   i_cfg_wdata,   // num_vars
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [15:0]       i_s_tdata,     // index, value_bit, zero pad
    input  wire logic [FUNC_W-1:0] i_s_tuser,     // func
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [7:0]             o_m_tdata,     // read_bit, zero pad
    output logic                   o_m_tuser      // index_error
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    logic       read_bit;

    tt2anf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    tt2anf_datapath #(
        .MAX_VARS (MAX_VARS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_func        (i_s_tuser),
        .i_index       (i_s_tdata[IDX_W-1:0]),
        .i_value_bit   (i_s_tdata[IDX_W]),
        .i_m_tready    (i_m_tready),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_m_tvalid),
        .o_read_bit    (read_bit),
        .o_index_error (o_m_tuser)
    );

    assign o_m_tdata = {7'b0, read_bit};

endmodule
`default_nettype wire

// ===== rtl/tt2anf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tt2anf_ctrl
// controller: accepts requests and sequences reads and transform levels
// ----------------------------------------------------------------------------
module tt2anf_ctrl
    import tt2anf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_m_tready,
    input  wire t_dp_status i_status,
    output logic            o_s_tready,
    output t_ctrl_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = !i_status.out_valid || i_m_tready;
                if (i_s_tvalid && o_s_tready) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.func == FUNC_READ && !i_status.idx_err) begin
                        n_state = S_READ;
                    end else if (i_status.func == FUNC_RUN && !i_status.run_err
                                 && !i_status.nv_zero) begin
                        o_cmd.run_start = 1'b1;
                        n_state         = S_RUN;
                    end else begin
                        o_cmd.load_imm = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.load_read = 1'b1;
                n_state         = S_IDLE;
            end
            S_RUN: begin
                o_cmd.run_issue = 1'b1;
                if (i_status.last_pair) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_status.last_level) begin
                    o_cmd.load_done = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.level_next = 1'b1;
                    n_state          = S_RUN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/tt2anf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tt2anf_datapath
// coefficient memory, butterfly address counters, config and result registers
// ----------------------------------------------------------------------------
module tt2anf_datapath
    import tt2anf_pkg::*;
#(
    parameter int MAX_VARS = DEF_MAX_VARS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [NV_W-1:0]   i_cfg_wdata,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic [IDX_W-1:0]  i_index,
    input  wire logic              i_value_bit,
    input  wire logic              i_m_tready,
    input  wire t_ctrl_cmd         i_cmd,
    output t_dp_status             o_status,
    output logic                   o_out_valid,
    output logic                   o_read_bit,
    output logic                   o_index_error
);

    localparam int AW    = MAX_VARS;
    localparam int DEPTH = 1 << AW;
    localparam int LW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

    logic            r_mem [DEPTH];
    logic [NV_W-1:0] r_num_vars;
    logic [LW-1:0]   r_lvl;
    logic [AW-1:0]   r_pair;
    logic            r_rd_a;
    logic            r_rd_b;
    logic            r_wr_pend;
    logic [AW-1:0]   r_wr_addr;
    logic            r_out_valid;
    logic            r_read_bit;
    logic            r_index_error;

    logic [NV_W:0]   nv_clamp;
    logic [XW-1:0]   idx_x;
    logic [XW-1:0]   bound;
    logic            idx_err;
    logic            run_err;
    logic            imm_err;
    logic [NV_W-1:0] nv_m1;
    logic [AW-1:0]   lvl_bit;
    logic [AW-1:0]   lvl_mask;
    logic [AW-1:0]   lo_addr;
    logic [AW-1:0]   hi_addr;
    logic [AW-1:0]   addr_a;
    logic            item_we;

    // range checks
    always_comb begin
        if (32'(r_num_vars) > MAX_VARS) begin
            nv_clamp = (NV_W+1)'(MAX_VARS);
            run_err  = 1'b1;
        end else begin
            nv_clamp = {1'b0, r_num_vars};
            run_err  = 1'b0;
        end
        idx_x   = XW'(i_index);
        bound   = XW'(1) << nv_clamp;
        idx_err = (idx_x >= bound);
        if (i_func == FUNC_WRITE || i_func == FUNC_READ) begin
            imm_err = idx_err;
        end else if (i_func == FUNC_RUN) begin
            imm_err = run_err;
        end else begin
            imm_err = 1'b0;
        end
    end

    // butterfly pair addresses
    always_comb begin
        nv_m1    = r_num_vars - NV_W'(1);
        lvl_bit  = AW'(1) << r_lvl;
        lvl_mask = lvl_bit - AW'(1);
        lo_addr  = ((r_pair & ~lvl_mask) << 1) | (r_pair & lvl_mask);
        hi_addr  = lo_addr | lvl_bit;
        addr_a   = i_cmd.run_issue ? lo_addr : idx_x[AW-1:0];
        item_we  = i_cmd.accept && (i_func == FUNC_WRITE) && !idx_err;
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[hi_addr];
        if (r_wr_pend) begin
            r_mem[r_wr_addr] <= r_rd_a ^ r_rd_b;
        end else if (item_we) begin
            r_mem[idx_x[AW-1:0]] <= i_value_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars  <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_vars <= i_cfg_wdata;
            end
            r_wr_pend <= i_cmd.run_issue;
            if (i_cmd.load_imm || i_cmd.load_read || i_cmd.load_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= hi_addr;
        if (i_cmd.run_start) begin
            r_lvl  <= '0;
            r_pair <= '0;
        end else if (i_cmd.level_next) begin
            r_lvl  <= r_lvl + LW'(1);
            r_pair <= '0;
        end else if (i_cmd.run_issue) begin
            r_pair <= r_pair + AW'(1);
        end
        if (i_cmd.load_imm) begin
            r_read_bit    <= 1'b0;
            r_index_error <= imm_err;
        end else if (i_cmd.load_read) begin
            r_read_bit    <= r_rd_a;
            r_index_error <= 1'b0;
        end else if (i_cmd.load_done) begin
            r_read_bit    <= 1'b0;
            r_index_error <= 1'b0;
        end
    end

    always_comb begin
        o_status.func       = i_func;
        o_status.idx_err    = idx_err;
        o_status.run_err    = run_err;
        o_status.nv_zero    = (r_num_vars == '0);
        o_status.last_pair  = (r_pair == ((AW'(1) << nv_m1) - AW'(1)));
        o_status.last_level = (5'(r_lvl) == {1'b0, nv_m1});
        o_status.out_valid  = r_out_valid;
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_bit    = r_read_bit;
    assign o_index_error = r_index_error;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the truth table to anf transform unit
// ----------------------------------------------------------------------------
// A short table of hand-picked requests runs first: single-entry tables,
// out-of-range writes and reads, the unused code, a run with too many
// variables and the widest table. Random phases follow. Each phase sets
// num_vars while the unit is idle; if num_vars is in range it then fills
// the active table, runs the transform and reads coefficients back. Every
// phase then mixes writes, reads, runs and refused accesses. A bit-level
// model in the bench predicts the random results; the table gives its own.
// Both stream sides insert random gaps, and some phases run with no gaps.
// ----------------------------------------------------------------------------
module tb;
    import tt2anf_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int unsigned STORE_DEPTH = 1 << IDX_W;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned RANDOM_ITEMS = 400;

    typedef struct packed {
        logic index_error;
        logic read_bit;
    } t_coef_result;

    typedef struct packed {
        bit                cfg;
        logic [NV_W-1:0]   nv;
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  idx;
        logic              val;
        bit                typed;
        logic              rd;
        logic              err;
    } t_dir_row;

    localparam t_dir_row DIRECTED [0:23] = '{
        '{1'b1, 4'd0,  FUNC_WRITE, 10'd0,    1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 4'd0,  FUNC_READ,  10'd0,    1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b0, 4'd0,  FUNC_WRITE, 10'd1,    1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b0, 4'd0,  FUNC_RUN,   10'd0,    1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 4'd0,  FUNC_READ,  10'd0,    1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 4'd0,  FUNC_READ,  10'd1023, 1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b1, 4'd2,  FUNC_WRITE, 10'd0,    1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 4'd2,  FUNC_WRITE, 10'd1,    1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 4'd2,  FUNC_WRITE, 10'd2,    1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 4'd2,  FUNC_WRITE, 10'd3,    1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 4'd2,  FUNC_READ,  10'd3,    1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b0, 4'd2,  FUNC_WRITE, 10'd1023, 1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b0, 4'd2,  FUNC_NOP,   10'd1023, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 4'd2,  FUNC_RUN,   10'd1023, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 4'd2,  FUNC_READ,  10'd3,    1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 4'd2,  FUNC_READ,  10'd1,    1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 4'd2,  FUNC_READ,  10'd4,    1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b1, 4'd15, FUNC_RUN,   10'd0,    1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b0, 4'd15, FUNC_WRITE, 10'd1023, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 4'd15, FUNC_READ,  10'd1023, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 4'd15, FUNC_READ,  10'd2,    1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 4'd10, FUNC_WRITE, 10'd1023, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 4'd10, FUNC_READ,  10'd1023, 1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b1, 4'd1,  FUNC_NOP,   10'd0,    1'b0, 1'b1, 1'b0, 1'b0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [NV_W-1:0]   i_cfg_wdata;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [15:0]       i_s_tdata;    // index, value_bit, zero pad
    logic [FUNC_W-1:0] i_s_tuser;    // func
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [7:0]        o_m_tdata;    // read_bit, zero pad
    logic              o_m_tuser;    // index_error

    // bench-side copy of the unit
    bit                coef_store [STORE_DEPTH];
    logic [NV_W-1:0]   model_nv;
    t_coef_result      expected_coefs [$];

    // stimulus bookkeeping
    bit                entry_set [STORE_DEPTH];
    logic [NV_W-1:0]   gen_nv;
    bit                cur_typed;
    t_coef_result      cur_result;
    bit                sender_burst;
    bit                receiver_burst;
    int unsigned       random_items;
    int unsigned       n_req;
    int unsigned       n_res;
    int unsigned       cycles;
    int unsigned       err_count;

    truth_table_to_anf_transform_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned tt_size(input logic [NV_W-1:0] nv);
        if (nv >= DEF_MAX_VARS)
            return STORE_DEPTH;
        return 1 << nv;
    endfunction

    function automatic void mobius_step(input logic [FUNC_W-1:0] func,
                                        input logic [IDX_W-1:0] idx,
                                        input logic val,
                                        output t_coef_result res);
        int unsigned lim;
        int unsigned half;
        int unsigned blk;
        int unsigned k;
        res = '0;
        lim = tt_size(model_nv);
        case (func)
            FUNC_WRITE, FUNC_READ: begin
                if (idx >= lim)
                    res.index_error = 1'b1;
                else if (func == FUNC_WRITE)
                    coef_store[idx] = val;
                else
                    res.read_bit = coef_store[idx];
            end
            FUNC_RUN: begin
                if (model_nv > DEF_MAX_VARS) begin
                    res.index_error = 1'b1;
                end else begin
                    for (int lvl = 0; lvl < model_nv; lvl++) begin
                        half = 1 << lvl;
                        for (blk = 0; blk < lim; blk += 2 * half)
                            for (k = 0; k < half; k++)
                                coef_store[blk + k + half] ^= coef_store[blk + k];
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report(input string what);
        err_count++;
        $display("tb: mismatch at cycle %0d: %s", cycles, what);
    endtask

    always @(posedge i_clk) begin
        t_coef_result res;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: errors");
            $finish;
        end else if (!i_rst_n) begin
            model_nv = '0;
        end else begin
            if (i_cfg_we)
                model_nv = i_cfg_wdata;
            if (i_s_tvalid && o_s_tready) begin
                mobius_step(i_s_tuser, i_s_tdata[IDX_W-1:0], i_s_tdata[IDX_W], res);
                if (cur_typed)
                    res = cur_result;
                expected_coefs = {expected_coefs, res};
                n_req++;
            end
            if (o_m_tvalid && i_m_tready) begin
                n_res++;
                if (expected_coefs.size() == 0) begin
                    report("result with no request pending");
                end else begin
                    res = expected_coefs.pop_front();
                    if (o_m_tdata[0] !== res.read_bit)
                        report($sformatf("read_bit %b, want %b", o_m_tdata[0], res.read_bit));
                    if (o_m_tuser !== res.index_error)
                        report($sformatf("index_error %b, want %b", o_m_tuser,
                                         res.index_error));
                end
            end
        end
    end

    // result side
    initial begin
        int unsigned stall;
        int unsigned target;
        i_m_tready = 1'b0;
        forever begin
            stall = receiver_burst ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            target = n_res + 1;
            do @(negedge i_clk); while (n_res < target);
        end
    end

    // called and returns at a falling edge
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                                input logic val, input bit typed = 1'b0,
                                input t_coef_result want = '0);
        int unsigned gap;
        int unsigned target;
        gap = sender_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_typed  = typed;
        cur_result = want;
        i_s_tuser  = func;
        i_s_tdata  = {5'b0, val, idx};
        i_s_tvalid = 1'b1;
        if (func == FUNC_WRITE && idx < tt_size(gen_nv))
            entry_set[idx] = 1'b1;
        if (!typed)
            random_items++;
        target = n_req + 1;
        do @(negedge i_clk); while (n_req < target);
    endtask

    task automatic set_num_vars(input logic [NV_W-1:0] nv);
        i_s_tvalid = 1'b0;
        while (expected_coefs.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = nv;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        gen_nv   = nv;
    endtask

    // fill, transform, read back when num_vars is in range, then a random mix
    task automatic run_phase(input logic [NV_W-1:0] nv);
        int unsigned lim;
        int unsigned n_mix;
        int unsigned pick;
        int unsigned idx;
        set_num_vars(nv);
        sender_burst   = ($urandom_range(0, 3) == 0);
        receiver_burst = ($urandom_range(0, 3) == 0);
        lim = tt_size(nv);
        if (nv <= DEF_MAX_VARS) begin
            for (int i = 0; i < lim; i++)
                send_request(FUNC_WRITE, IDX_W'(i), 1'($urandom_range(0, 1)));
            send_request(FUNC_RUN, IDX_W'($urandom_range(0, 1023)),
                         1'($urandom_range(0, 1)));
            for (int i = 0; i < (lim < 16 ? lim : 16); i++)
                send_request(FUNC_READ,
                             IDX_W'(lim <= 16 ? i : $urandom_range(0, lim - 1)),
                             1'($urandom_range(0, 1)));
        end
        n_mix = $urandom_range(12, 40);
        for (int i = 0; i < n_mix; i++) begin
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, lim - 1);
            if (pick < 30 || (pick < 60 && !entry_set[idx])) begin
                send_request(FUNC_WRITE, IDX_W'(idx), 1'($urandom_range(0, 1)));
            end else if (pick < 60) begin
                send_request(FUNC_READ, IDX_W'(idx), 1'($urandom_range(0, 1)));
            end else if (pick < 75) begin
                send_request(FUNC_RUN, IDX_W'($urandom_range(0, 1023)),
                             1'($urandom_range(0, 1)));
            end else if (pick < 80) begin
                send_request(FUNC_NOP, IDX_W'($urandom_range(0, 1023)),
                             1'($urandom_range(0, 1)));
            end else if (lim < STORE_DEPTH) begin
                send_request($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE,
                             IDX_W'($urandom_range(lim, STORE_DEPTH - 1)),
                             1'($urandom_range(0, 1)));
            end else if (entry_set[idx]) begin
                send_request(FUNC_READ, IDX_W'(idx), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        int unsigned pick;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = FUNC_WRITE;
        gen_nv      = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < $size(DIRECTED); r++) begin
            if (DIRECTED[r].cfg)
                set_num_vars(DIRECTED[r].nv);
            send_request(DIRECTED[r].func, DIRECTED[r].idx, DIRECTED[r].val,
                         DIRECTED[r].typed,
                         t_coef_result'{DIRECTED[r].err, DIRECTED[r].rd});
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                run_phase(4'd0);
            else if (pick == 1)
                run_phase(NV_W'($urandom_range(DEF_MAX_VARS + 1, 15)));
            else
                run_phase(NV_W'($urandom_range(1, 6)));
        end

        i_s_tvalid = 1'b0;
        while (expected_coefs.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (expected_coefs.size() != 0)
            report($sformatf("%0d results never arrived", expected_coefs.size()));
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tt2anf_pkg.sv
rtl/tt2anf_ctrl.sv
rtl/tt2anf_datapath.sv
rtl/truth_table_to_anf_transform_unit.sv
dv/tb.sv
